// File: src/mf3_pkg.sv
package mf3_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration register layout
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int WIDTH_RESET    = 1024;
  localparam int HEIGHT_RESET   = 768;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMG_WIDTH  = 2'd0,
    REG_IMG_HEIGHT = 2'd1
  } cfg_reg_t;

  // Result buffer depth, covers the sort pipeline plus slack
  localparam int FIFO_DEPTH = 8;

  // Per-slot padding of the 3x3 window: lo forces zero, hi forces full scale
  typedef struct packed {
    logic [8:0] lo;
    logic [8:0] hi;
  } pad_t;

  typedef struct packed {
    logic eor;
    logic eof;
  } res_tag_t;

  // Pick pad values for the out-of-frame slots so that the fixed 9-input
  // median lands on the upper middle of the in-frame values. With n values
  // in frame, 4 - (n >> 1) slots go low and the rest go high.
  function automatic pad_t pad_select(logic top_ok, logic bot_ok, logic left_ok,
                                      logic right_ok);
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [3:0] n;
    logic [3:0] lo_left;
    pad_t       r;
    row_ok = {bot_ok, 1'b1, top_ok};
    col_ok = {right_ok, 1'b1, left_ok};
    n      = 4'd0;
    r      = '0;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        if (row_ok[rr] && col_ok[cc]) begin
          n = n + 4'd1;
        end
      end
    end
    lo_left = 4'd4 - {1'b0, n[3:1]};
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        if (!(row_ok[rr] && col_ok[cc])) begin
          if (lo_left != 4'd0) begin
            r.lo[rr*3+cc] = 1'b1;
            lo_left       = lo_left - 4'd1;
          end else begin
            r.hi[rr*3+cc] = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// File: src/mf3_ram.sv
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/median_filter_3x3.sv
// 3x3 median filter for a raster-order stream of gray pixels.
// Input channel (src_valid/src_stall): one beat per pixel, in_pixel and drain.
// After the last pixel of a frame the source sends img_width+1 drain beats to
// flush the remaining results; a drain beat while pixels are still expected
// is taken and dropped.
// Output channel (res_valid/res_stall): one beat per pixel of the frame, with
// end_of_row and end_of_frame flags. Each result is the median of the in-frame
// part of the neighborhood (upper middle when the count is even).
// Result path: each result is produced by the beat one row plus one pixel after
// its pixel and passes the memory stage and sort pipeline into the result buffer.
// Throughput: one beat per cycle while src_stall is low, set by the line memory,
// which is read and written back once per beat. src_stall rises only when the
// 8-entry result buffer, counting results still in the sort pipeline, is full,
// so a stalled receiver holds the input off after at most 8 pending results.
// Configuration: cfg_we writes img_width (index 0) or img_height (index 1); the user
// must do so while the block is idle, which the block does not enforce; a write restarts the frame.
// Reset: synchronous; frame restarts at min(1024, MAX_WIDTH) x 768, the result buffer empties.
// The line memory is not cleared: rows above the frame are never used.
module median_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // pixel input
  input  logic                      src_valid,
  output logic                      src_stall,
  input  logic [PIXEL_BITS-1:0]     in_pixel,
  input  logic                      drain,
  // filtered output
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [PIXEL_BITS-1:0]     filtered_pixel,
  output logic                      end_of_row,
  output logic                      end_of_frame
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = HEIGHT_BITS + 1;
  localparam int WIDE    = (COL_W + 1 > WIDTH_BITS) ? COL_W + 1 : WIDTH_BITS;
  localparam int W_RST   = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = FIFO_AW + 1;

  typedef logic [8:0][PIXEL_BITS-1:0] pix9_t;
  typedef logic [2:0][PIXEL_BITS-1:0] col3_t;

  // configuration and position state
  logic [COL_W-1:0]       width_m1;
  logic [HEIGHT_BITS-1:0] height_m1;
  logic [COL_W-1:0]       in_col;
  logic [ROW_W-1:0]       in_row;
  logic [COL_W-1:0]       out_col;
  logic [HEIGHT_BITS-1:0] out_row;

  logic                   cfg_w_hit;
  logic                   cfg_h_hit;
  logic [WIDE-1:0]        w_wr;
  logic [WIDE-1:0]        w_eff;
  logic [COL_W-1:0]       width_m1_wr;
  logic [HEIGHT_BITS-1:0] height_m1_wr;

  // input stage
  logic                   src_accept;
  logic                   pixels_done;
  logic                   active;
  logic                   emit;
  logic                   eor;
  logic                   eof;
  logic [PIXEL_BITS-1:0]  pix_val;
  pad_t                   pad;

  // memory stage
  logic                    s1_valid;
  logic                    s1_emit;
  logic [COL_W-1:0]        s1_col;
  logic [PIXEL_BITS-1:0]   s1_val;
  pad_t                    s1_pad;
  res_tag_t                s1_tag;
  logic [2*PIXEL_BITS-1:0] ram_q;
  logic [2*PIXEL_BITS-1:0] ram_wdata;
  logic                    fwd_hit;
  logic [2*PIXEL_BITS-1:0] fwd_data;
  logic [2*PIXEL_BITS-1:0] lines;
  col3_t                   col_new;
  col3_t                   win_b;
  col3_t                   win_c;
  pix9_t                   window;

  // sort pipeline
  logic     s2_v;
  logic     s3_v;
  logic     s4_v;
  pix9_t    s2_p;
  pix9_t    s3_p;
  pix9_t    s4_p;
  res_tag_t s2_tag;
  res_tag_t s3_tag;
  res_tag_t s4_tag;
  pix9_t    lay_a;
  pix9_t    lay_b;
  pix9_t    lay_c;

  // result buffer
  logic [PIXEL_BITS-1:0] fifo_pix [FIFO_DEPTH];
  res_tag_t              fifo_tag [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr;
  logic [FIFO_AW-1:0]    rd_ptr;
  logic [CNT_W-1:0]      fifo_count;
  logic                  pop;
  logic [CNT_W:0]        credit_used;

  // Order two window slots ascending
  function automatic pix9_t cswap(pix9_t p, logic [3:0] i, logic [3:0] j);
    pix9_t r;
    r = p;
    if (p[i] > p[j]) begin
      r[i] = p[j];
      r[j] = p[i];
    end
    return r;
  endfunction

  // Decode configuration writes, clamp to the supported range
  always_comb begin
    cfg_w_hit    = cfg_we && (cfg_index == REG_IMG_WIDTH);
    cfg_h_hit    = cfg_we && (cfg_index == REG_IMG_HEIGHT);
    w_wr         = WIDE'(cfg_data[WIDTH_BITS-1:0]);
    if (w_wr == '0) begin
      w_eff = WIDE'(1);
    end else if (w_wr > WIDE'(MAX_WIDTH)) begin
      w_eff = WIDE'(MAX_WIDTH);
    end else begin
      w_eff = w_wr;
    end
    width_m1_wr  = COL_W'(w_eff - WIDE'(1));
    height_m1_wr = (cfg_data[HEIGHT_BITS-1:0] == '0) ? '0
                                                     : cfg_data[HEIGHT_BITS-1:0] - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= COL_W'(W_RST - 1);
      height_m1 <= HEIGHT_BITS'(HEIGHT_RESET - 1);
    end else begin
      if (cfg_w_hit) begin
        width_m1 <= width_m1_wr;
      end
      if (cfg_h_hit) begin
        height_m1 <= height_m1_wr;
      end
    end
  end

  // Classify the beat: drop a drain beat while pixels are still expected
  always_comb begin
    src_accept  = src_valid && !src_stall;
    pixels_done = in_row > {1'b0, height_m1};
    active      = src_accept && !(drain && !pixels_done);
    pix_val     = pixels_done ? '0 : in_pixel;
    emit        = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_col != '0));
    eor         = (out_col == width_m1);
    eof         = eor && (out_row == height_m1);
    pad         = pad_select(out_row != '0, out_row != height_m1,
                             out_col != '0, out_col != width_m1);
  end

  // Advance input and output positions; restart on reset, a config write or after the last result
  always_ff @(posedge clk) begin
    if (rst || cfg_w_hit || cfg_h_hit) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (active) begin
      if (emit && eof) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col == width_m1) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (emit) begin
          if (out_col == width_m1) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Hand the beat to the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= active;
      s1_emit  <= active && emit;
      fwd_hit  <= s1_valid && (s1_col == in_col);
    end
    s1_col   <= in_col;
    s1_val   <= pix_val;
    s1_pad   <= pad;
    s1_tag   <= '{eor: eor, eof: eof};
    fwd_data <= ram_wdata;
  end

  // Line memory: per column, the two rows above the incoming pixel
  mf3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .raddr (in_col),
    .rdata (ram_q)
  );

  // Forward the word written at the same edge as this read; build the column
  always_comb begin
    lines     = fwd_hit ? fwd_data : ram_q;
    col_new   = {s1_val, lines[PIXEL_BITS-1:0], lines[2*PIXEL_BITS-1:PIXEL_BITS]};
    ram_wdata = {lines[PIXEL_BITS-1:0], s1_val};
    for (int rr = 0; rr < 3; rr++) begin
      window[rr*3]   = win_c[rr];
      window[rr*3+1] = win_b[rr];
      window[rr*3+2] = col_new[rr];
    end
    for (int s = 0; s < 9; s++) begin
      if (s1_pad.lo[s]) begin
        window[s] = '0;
      end else if (s1_pad.hi[s]) begin
        window[s] = '1;
      end
    end
  end

  // Shift the window by one column per stored beat
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win_b <= col_new;
      win_c <= win_b;
    end
  end

  // Median network in three layers
  always_comb begin
    lay_a = s2_p;
    lay_a = cswap(lay_a, 4'd1, 4'd2);
    lay_a = cswap(lay_a, 4'd4, 4'd5);
    lay_a = cswap(lay_a, 4'd7, 4'd8);
    lay_a = cswap(lay_a, 4'd0, 4'd1);
    lay_a = cswap(lay_a, 4'd3, 4'd4);
    lay_a = cswap(lay_a, 4'd6, 4'd7);
    lay_a = cswap(lay_a, 4'd1, 4'd2);
    lay_a = cswap(lay_a, 4'd4, 4'd5);
    lay_a = cswap(lay_a, 4'd7, 4'd8);

    lay_b = s3_p;
    lay_b = cswap(lay_b, 4'd0, 4'd3);
    lay_b = cswap(lay_b, 4'd5, 4'd8);
    lay_b = cswap(lay_b, 4'd4, 4'd7);
    lay_b = cswap(lay_b, 4'd3, 4'd6);
    lay_b = cswap(lay_b, 4'd1, 4'd4);
    lay_b = cswap(lay_b, 4'd2, 4'd5);
    lay_b = cswap(lay_b, 4'd4, 4'd7);

    lay_c = s4_p;
    lay_c = cswap(lay_c, 4'd4, 4'd2);
    lay_c = cswap(lay_c, 4'd6, 4'd4);
    lay_c = cswap(lay_c, 4'd4, 4'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s2_v <= s1_emit;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s2_p   <= window;
    s2_tag <= s1_tag;
    s3_p   <= lay_a;
    s3_tag <= s2_tag;
    s4_p   <= lay_b;
    s4_tag <= s3_tag;
  end

  // Result buffer; hold the input off once every slot is spoken for
  always_comb begin
    pop         = res_valid && !res_stall;
    credit_used = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(s1_emit) + (CNT_W+1)'(s2_v)
                + (CNT_W+1)'(s3_v) + (CNT_W+1)'(s4_v);
    src_stall   = credit_used >= (CNT_W+1)'(FIFO_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s4_v) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + CNT_W'(s4_v) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v) begin
      fifo_pix[wr_ptr] <= lay_c[4];
      fifo_tag[wr_ptr] <= s4_tag;
    end
  end

  assign res_valid      = (fifo_count != '0);
  assign filtered_pixel = fifo_pix[rd_ptr];
  assign end_of_row     = fifo_tag[rd_ptr].eor;
  assign end_of_frame   = fifo_tag[rd_ptr].eof;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= (CNT_W+1)'(FIFO_DEPTH))
    else $error("results in flight exceed the result buffer");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    s4_v |-> ((fifo_count != CNT_W'(FIFO_DEPTH)) || pop))
    else $error("result pushed into a full buffer");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (active && emit && eof) |=> ((in_col == '0) && (in_row == '0) && (out_col == '0)
                                 && (out_row == '0)))
    else $error("positions not restarted after the last result of a frame");

  a_pos_bounds: assert property (@(posedge clk) disable iff (rst)
    (in_col <= width_m1) && (out_col <= width_m1) && (out_row <= height_m1))
    else $error("position counter beyond the frame");
`endif

endmodule
